### rtl/separable_convolution_2d_assert.svh
// Assertion macros shared by the separable convolution RTL.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef SEPARABLE_CONVOLUTION_2D_ASSERT_SVH
`define SEPARABLE_CONVOLUTION_2D_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SC2D_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SC2D_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sc2d_pkg.sv
// Package for the separable 2-D convolution filter: field widths, defaults,
// register indexes and the tap extraction function. No dependencies.
`default_nettype none

package sc2d_pkg;

    localparam int unsigned DEF_MAX_WIDTH      = 2048;
    localparam int unsigned DEF_MAX_HEIGHT     = 2048;
    localparam int unsigned DEF_MAX_HALF       = 3;
    localparam int unsigned DEF_COEF_FRAC_BITS = 13;

    localparam int unsigned PIXEL_W   = 8;
    localparam int unsigned POS_W     = 11;
    localparam int unsigned VALUE_W   = 24;
    localparam int unsigned HSUM_W    = 16;
    localparam int unsigned TAP_W     = 16;
    localparam int unsigned SIZE_W    = 12;
    localparam int unsigned HALF_W    = 2;
    localparam int unsigned TAPS_LO_W = 64;
    localparam int unsigned TAPS_HI_W = 48;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HALF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_H_TAPS_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_H_TAPS_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_V_TAPS_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_V_TAPS_HIGH  = 3'd6;

    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [HALF_W-1:0] RST_KERNEL_HALF  = 2'd1;

    // Taps 0 to 3 come from the low word; higher taps cycle through the
    // four 16-bit lanes of the high word, the top lane reading as zero.
    function automatic logic signed [TAP_W-1:0] get_tap(
        input logic [TAPS_LO_W-1:0] lo,
        input logic [TAPS_HI_W-1:0] hi,
        input int unsigned k
    );
        logic [63:0] t;
        if (k < 4) begin
            t = lo >> (16 * k);
        end else begin
            t = {16'b0, hi} >> (16 * ((k - 4) & 3));
        end
        return t[TAP_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/sc2d_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module sc2d_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/separable_convolution_2d.sv
// Separable 2-D convolution of an 8-bit gray raster stream: a horizontal
// kernel, then a vertical kernel, each of 2h+1 signed Q2.13 taps, with zero
// borders h wide. The block accepts one pixel per cycle. A pixel that
// reports r results holds the result sequencer until all are out (r is 0
// or 1 inside a row, 0 or h+1 in the last row, h+1 on a row's last pixel,
// up to (h+1)*(h+1) on the frame's last pixel), so input stalls during
// those flushes and while m_ready holds results back. Horizontal sums of
// the last 2*MAX_HALF rows live in one RAM per ring row slot, so all vertical
// taps are read in the same cycle; the store needs no clearing after reset.
// Depends on sc2d_pkg, sc2d_ram and separable_convolution_2d_assert.svh.
`default_nettype none

`include "separable_convolution_2d_assert.svh"

module separable_convolution_2d import sc2d_pkg::*; #(
    parameter int unsigned MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int unsigned MAX_HALF       = DEF_MAX_HALF,
    parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [PIXEL_W-1:0]         s_pixel,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [POS_W-1:0]                m_out_row,
    output logic [POS_W-1:0]                m_out_col,
    output logic signed [VALUE_W-1:0]       m_value,
    output logic                            m_last
);

    localparam int unsigned RING = 2 * MAX_HALF;
    localparam int unsigned NT   = RING + 1;
    localparam int unsigned CW   = $clog2(MAX_WIDTH);
    localparam int unsigned RW   = $clog2(MAX_HEIGHT);
    localparam int unsigned SW   = $clog2(RING);
    localparam int unsigned TW   = $clog2(NT + 1);
    localparam int unsigned PH_W = TAP_W + PIXEL_W + 1;
    localparam int unsigned PV_W = TAP_W + HSUM_W;
    localparam int unsigned HS_W = PH_W + $clog2(NT) + 1;
    localparam int unsigned VS_W = PV_W + $clog2(NT) + 1;

    localparam logic signed [HS_W-1:0] H_HALF = HS_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [VS_W-1:0] V_HALF = VS_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [HS_W-1:0] H_MAX  = HS_W'(32767);
    localparam logic signed [HS_W-1:0] H_MIN  = -HS_W'(32768);
    localparam logic signed [VS_W-1:0] V_MAX  = VS_W'(8388607);
    localparam logic signed [VS_W-1:0] V_MIN  = -VS_W'(8388608);

    typedef struct packed {
        logic          compute_h;
        logic          interior;
        logic          has;
        logic [CW-1:0] j;
        logic [SW-1:0] slot;
        logic [RW-1:0] rlo;
        logic [RW-1:0] rhi;
        logic [CW-1:0] clo;
        logic [CW-1:0] chi;
    } meta_t;

    // Configuration registers.
    logic [SIZE_W-1:0]    frame_width_reg, frame_height_reg;
    logic [HALF_W-1:0]    kernel_half_reg;
    logic [TAPS_LO_W-1:0] h_taps_low_reg, v_taps_low_reg;
    logic [TAPS_HI_W-1:0] h_taps_high_reg, v_taps_high_reg;

    // Position state and the pixel window.
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [PIXEL_W-1:0] win_reg [RING];

    // Pipeline registers.
    logic                       s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    meta_t                      s1_meta_reg, s2_meta_reg, s3_meta_reg, s4_meta_reg, s5_meta_reg;
    logic [PIXEL_W-1:0]         s1_op_reg [NT];
    logic signed [PH_W-1:0]     s2_prod_reg [NT];
    logic signed [HSUM_W-1:0]   s3_hv_reg;
    logic signed [PV_W-1:0]     s4_prod_reg [NT];
    logic signed [VALUE_W-1:0]  s5_vval_reg;
    logic [RW-1:0]              s5_i_reg;
    logic [CW-1:0]              s5_j_reg;
    logic                       s5_first_reg;

    logic                       m_valid_reg, m_last_reg;
    logic [POS_W-1:0]           m_row_reg, m_col_reg;
    logic signed [VALUE_W-1:0]  m_value_reg;

    // Decode of the incoming pixel's position.
    logic [HALF_W-1:0] hc;
    logic [2:0]        h2;
    logic [CW:0]       wd_eff;
    logic [RW:0]       ht_eff;
    logic              last_col, last_row;
    meta_t             s0_meta;

    logic signed [TAP_W-1:0] h_tap [NT];
    logic signed [TAP_W-1:0] v_tap [NT];

    logic take1, take2, take3, take4, take5;
    logic out_free, s5_final, s5_emit, s5_done;
    logic accept;

    logic signed [HS_W-1:0]   hsum, hq;
    logic signed [HSUM_W-1:0] hv;
    logic signed [VS_W-1:0]   vsum, vq;
    logic signed [VALUE_W-1:0] vval;

    logic [RING-1:0]         ram_we;
    logic [HSUM_W-1:0]       ram_rd [RING];
    logic signed [HSUM_W-1:0] vrow [NT];
    logic                    ram_rd_en;

    for (genvar a = 0; a < NT; a++) begin : g_taps
        assign h_tap[a] = get_tap(h_taps_low_reg, h_taps_high_reg, a);
        assign v_tap[a] = get_tap(v_taps_low_reg, v_taps_high_reg, a);
    end

    always_comb begin
        hc = (kernel_half_reg > MAX_HALF) ? HALF_W'(MAX_HALF) : kernel_half_reg;
        h2 = {1'b0, hc} << 1;
        if (frame_width_reg == '0) begin
            wd_eff = (CW+1)'(1);
        end else if (frame_width_reg > MAX_WIDTH) begin
            wd_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            wd_eff = (CW+1)'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            ht_eff = (RW+1)'(1);
        end else if (frame_height_reg > MAX_HEIGHT) begin
            ht_eff = (RW+1)'(MAX_HEIGHT);
        end else begin
            ht_eff = (RW+1)'(frame_height_reg);
        end

        last_col = ({1'b0, col_reg} + (CW+1)'(1)) >= wd_eff;
        last_row = ({1'b0, row_reg} + (RW+1)'(1)) >= ht_eff;

        s0_meta.compute_h = (col_reg >= h2) && ({1'b0, col_reg} < wd_eff);
        s0_meta.interior  = s0_meta.compute_h && (row_reg >= h2)
                            && ({1'b0, row_reg} < ht_eff);
        s0_meta.has       = ((row_reg >= hc) || last_row) && ((col_reg >= hc) || last_col);
        s0_meta.j         = col_reg - CW'(hc);
        s0_meta.slot      = slot_reg;
        s0_meta.rlo       = (row_reg >= hc) ? row_reg - RW'(hc) : '0;
        s0_meta.rhi       = last_row ? row_reg : row_reg - RW'(hc);
        s0_meta.clo       = (col_reg >= hc) ? col_reg - CW'(hc) : '0;
        s0_meta.chi       = last_col ? col_reg : col_reg - CW'(hc);

        if (last_col) begin
            col_next = '0;
            if (last_row) begin
                row_next  = '0;
                slot_next = '0;
            end else begin
                row_next  = row_reg + RW'(1);
                slot_next = (slot_reg == SW'(RING - 1)) ? '0 : slot_reg + SW'(1);
            end
        end else begin
            col_next  = col_reg + CW'(1);
            row_next  = row_reg;
            slot_next = slot_reg;
        end
    end

    // Handshake chain: a stage takes a new transaction when it is empty or
    // its content moves on in the same cycle.
    always_comb begin
        out_free = !m_valid_reg || m_ready;
        s5_final = (s5_i_reg == s5_meta_reg.rhi) && (s5_j_reg == s5_meta_reg.chi);
        s5_emit  = s5_vld_reg && s5_meta_reg.has && out_free;
        s5_done  = s5_vld_reg && (!s5_meta_reg.has || (out_free && s5_final));
        take5    = !s5_vld_reg || s5_done;
        take4    = !s4_vld_reg || take5;
        take3    = !s3_vld_reg || take4;
        take2    = !s2_vld_reg || take3;
        take1    = !s1_vld_reg || take2;
        accept   = s_valid && take1;
    end

    assign s_ready = take1;

    // Horizontal sum, rounding and saturation.
    always_comb begin
        hsum = '0;
        for (int a = 0; a < NT; a++) begin
            hsum = hsum + HS_W'(s2_prod_reg[a]);
        end
        hq = (hsum + H_HALF) >>> COEF_FRAC_BITS;
        if (hq > H_MAX) begin
            hv = HSUM_W'(H_MAX);
        end else if (hq < H_MIN) begin
            hv = HSUM_W'(H_MIN);
        end else begin
            hv = HSUM_W'(hq);
        end
    end

    // Row store: one RAM per ring slot, written and read as a transaction
    // moves from the second to the third stage.
    assign ram_rd_en = s2_vld_reg && take3;

    for (genvar k = 0; k < RING; k++) begin : g_rows
        assign ram_we[k] = ram_rd_en && s2_meta_reg.compute_h
                           && (s2_meta_reg.slot == SW'(k));
        sc2d_ram #(
            .WIDTH (HSUM_W),
            .DEPTH (MAX_WIDTH)
        ) u_row_ram (
            .clk     (aclk),
            .wr_en   (ram_we[k]),
            .wr_addr (s2_meta_reg.j),
            .wr_data (hv),
            .rd_en   (ram_rd_en),
            .rd_addr (s2_meta_reg.j),
            .rd_data (ram_rd[k])
        );
    end

    // Row a back from the current one sits in slot (slot - a) modulo RING.
    always_comb begin
        logic [SW:0] sel;
        vrow[0] = s3_hv_reg;
        for (int a = 1; a < NT; a++) begin
            sel = {1'b0, s3_meta_reg.slot} + (SW+1)'(RING - a);
            if (sel >= (SW+1)'(RING)) begin
                sel = sel - (SW+1)'(RING);
            end
            if (TW'(a) <= TW'(h2)) begin
                vrow[a] = ram_rd[sel[SW-1:0]];
            end else begin
                vrow[a] = '0;
            end
        end
    end

    // Vertical sum, rounding and saturation.
    always_comb begin
        vsum = '0;
        for (int a = 0; a < NT; a++) begin
            vsum = vsum + VS_W'(s4_prod_reg[a]);
        end
        vq = (vsum + V_HALF) >>> COEF_FRAC_BITS;
        if (vq > V_MAX) begin
            vval = VALUE_W'(V_MAX);
        end else if (vq < V_MIN) begin
            vval = VALUE_W'(V_MIN);
        end else begin
            vval = VALUE_W'(vq);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            kernel_half_reg  <= RST_KERNEL_HALF;
            h_taps_low_reg   <= '0;
            h_taps_high_reg  <= '0;
            v_taps_low_reg   <= '0;
            v_taps_high_reg  <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
            slot_reg         <= '0;
            for (int a = 0; a < RING; a++) begin
                win_reg[a] <= '0;
            end
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[SIZE_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[SIZE_W-1:0];
                    CFG_KERNEL_HALF:  kernel_half_reg  <= cfg_wdata[HALF_W-1:0];
                    CFG_H_TAPS_LOW:   h_taps_low_reg   <= cfg_wdata[TAPS_LO_W-1:0];
                    CFG_H_TAPS_HIGH:  h_taps_high_reg  <= cfg_wdata[TAPS_HI_W-1:0];
                    CFG_V_TAPS_LOW:   v_taps_low_reg   <= cfg_wdata[TAPS_LO_W-1:0];
                    CFG_V_TAPS_HIGH:  v_taps_high_reg  <= cfg_wdata[TAPS_HI_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                slot_reg <= slot_next;
                win_reg[0] <= s_pixel;
                for (int a = 1; a < RING; a++) begin
                    win_reg[a] <= win_reg[a-1];
                end
            end

            if (take1) s1_vld_reg <= s_valid;
            if (take2) s2_vld_reg <= s1_vld_reg;
            if (take3) s3_vld_reg <= s2_vld_reg;
            if (take4) s4_vld_reg <= s3_vld_reg;
            if (take5) s5_vld_reg <= s4_vld_reg;

            if (s5_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_meta_reg  <= s0_meta;
            s1_op_reg[0] <= s_pixel;
            for (int a = 1; a < NT; a++) begin
                s1_op_reg[a] <= (TW'(a) <= TW'(h2)) ? win_reg[a-1] : '0;
            end
        end
        if (take2 && s1_vld_reg) begin
            s2_meta_reg <= s1_meta_reg;
            for (int a = 0; a < NT; a++) begin
                s2_prod_reg[a] <= PH_W'(h_tap[a]) * PH_W'($signed({1'b0, s1_op_reg[a]}));
            end
        end
        if (take3 && s2_vld_reg) begin
            s3_meta_reg <= s2_meta_reg;
            s3_hv_reg   <= hv;
        end
        if (take4 && s3_vld_reg) begin
            s4_meta_reg <= s3_meta_reg;
            for (int a = 0; a < NT; a++) begin
                s4_prod_reg[a] <= PV_W'(v_tap[a]) * PV_W'(vrow[a]);
            end
        end
        if (take5 && s4_vld_reg) begin
            s5_meta_reg  <= s4_meta_reg;
            s5_vval_reg  <= vval;
            s5_i_reg     <= s4_meta_reg.rlo;
            s5_j_reg     <= s4_meta_reg.clo;
            s5_first_reg <= 1'b1;
        end else if (s5_emit && !s5_final) begin
            s5_first_reg <= 1'b0;
            if (s5_j_reg == s5_meta_reg.chi) begin
                s5_j_reg <= s5_meta_reg.clo;
                s5_i_reg <= s5_i_reg + RW'(1);
            end else begin
                s5_j_reg <= s5_j_reg + CW'(1);
            end
        end
        if (s5_emit) begin
            m_row_reg   <= POS_W'(s5_i_reg);
            m_col_reg   <= POS_W'(s5_j_reg);
            // Only the first result of a transaction is the filtered pixel;
            // the rest are flushed border positions.
            m_value_reg <= (s5_first_reg && s5_meta_reg.interior) ? s5_vval_reg : '0;
            m_last_reg  <= s5_final;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_row = m_row_reg;
    assign m_out_col = m_col_reg;
    assign m_value   = m_value_reg;
    assign m_last    = m_last_reg;

    `SC2D_ASSERT_NXT(a_reset_clears_out, aclk, 1'b1, !aresetn, !m_valid_reg, "result valid after reset")
    `SC2D_ASSERT_IMP(a_seq_in_range, aclk, aresetn, s5_vld_reg && s5_meta_reg.has, (s5_i_reg <= s5_meta_reg.rhi) && (s5_j_reg <= s5_meta_reg.chi), "sequencer left its range")
    `SC2D_ASSERT_IMP(a_one_row_write, aclk, aresetn, 1'b1, $onehot0(ram_we), "row store written in two slots")
    `SC2D_ASSERT_NXT(a_col_wraps, aclk, aresetn, accept && last_col, col_reg == '0, "column did not wrap at row end")

endmodule

`default_nettype wire
